// ----- hdl/assert_macros.svh -----
// assertion macros used by the point in polygon tester
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/pip_pkg.sv -----
// shared types, constants and helpers of the point in polygon tester
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_W          = 16;
  localparam int DIFF_W           = COORD_W + 1;
  localparam int PROD_W           = 2 * DIFF_W;
  localparam int INDEX_W          = 6;
  localparam int COUNT_W          = 7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef struct packed {
    logic    en;
    index_t  index;
    vertex_t v;
  } load_t;

  // edge test waiting for its final compare in the next cell or the tail stage
  typedef struct packed {
    logic  take;
    logic  dy_pos;
    prod_t lhs;
    prod_t rhs;
  } pend_t;

  typedef struct packed {
    logic    valid;
    vertex_t pt;
    logic    parity;
    pend_t   pend;
  } token_t;

  // sign corrected compare of the intersection against px
  function automatic logic crosses(pend_t p);
    logic gt;
    logic lt;
    gt = $signed(p.lhs) > $signed(p.rhs);
    lt = $signed(p.lhs) < $signed(p.rhs);
    return p.take && (p.dy_pos ? gt : lt);
  endfunction

endpackage

// ----- hdl/pip_if.sv -----
// stream interfaces of the point in polygon tester
interface pip_item_if;
  logic            valid;
  logic            ready;
  logic            mode;
  pip_pkg::index_t vertex_index;
  pip_pkg::coord_t coord_x;
  pip_pkg::coord_t coord_y;
  modport source(output valid, mode, vertex_index, coord_x, coord_y, input ready);
  modport sink(input valid, mode, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_result_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source(output valid, inside_res, input ready);
  modport sink(input valid, inside_res, output ready);
endinterface

interface pip_cfg_if;
  logic            valid;
  logic            ready;
  pip_pkg::count_t vertex_count;
  modport source(output valid, vertex_count, input ready);
  modport sink(input valid, vertex_count, output ready);
endinterface

// ----- hdl/point_in_polygon_test.sv -----
// point in polygon tester: a query passes the cell registers, the tail stage and the output register
// a query walks a row of MAX_VERTICES cells, one cell per cycle, one edge per cell
// one query in flight, so a new query is accepted only once the last has left the tail stage
// a load transaction writes one vertex cell and gives no result
// synchronous active-high reset clears the vertex count and all control state
// vertex coordinates are not reset and read as undefined until loaded
`include "assert_macros.svh"

module point_in_polygon_test #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input logic             clk,
  input logic             rst,
  pip_item_if.sink        items,
  pip_result_if.source    results,
  pip_cfg_if.sink         cfg
);

  // configuration
  pip_pkg::count_t  vertex_count;
  pip_pkg::count_t  n_eff;

  // cell row wiring
  pip_pkg::vertex_t verts [MAX_VERTICES];
  pip_pkg::token_t  tok [MAX_VERTICES+1];
  logic [MAX_VERTICES-1:0] tok_valid_vec;
  pip_pkg::load_t   load;
  pip_pkg::token_t  last_tok;

  // control and result staging
  logic busy;
  logic tail_valid;
  logic tail_parity;
  logic res_valid;
  logic res_parity;
  logic item_acc;
  logic tail_move;

  // vertex count register, writable at any time the block is idle
  assign cfg.ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      vertex_count <= cfg.vertex_count;
    end
  end

  // counts beyond capacity behave as a full table
  assign n_eff = (32'(vertex_count) > MAX_VERTICES) ? pip_pkg::COUNT_W'(MAX_VERTICES)
                                                     : vertex_count;

  // input side: load transactions write a cell, queries enter the row
  assign items.ready = !busy;
  assign item_acc    = items.valid && items.ready;

  always_comb begin
    load.en    = item_acc && !items.mode;
    load.index = items.vertex_index;
    load.v.x   = items.coord_x;
    load.v.y   = items.coord_y;

    tok[0]             = '0;
    tok[0].valid       = item_acc && items.mode;
    tok[0].pt.x        = items.coord_x;
    tok[0].pt.y        = items.coord_y;
    tok[0].parity      = 1'b0;
    tok[0].pend.take   = 1'b0;
  end

  // row of cells; cell i owns vertex i and tests edge i to its successor
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pip_cell #(
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .load    (load),
      .n_eff   (n_eff),
      .v_next  (verts[(i + 1) % MAX_VERTICES]),
      .v_first (verts[0]),
      .tok_in  (tok[i]),
      .vertex  (verts[i]),
      .tok_out (tok[i+1])
    );
    assign tok_valid_vec[i] = tok[i+1].valid;
  end

  assign last_tok = tok[MAX_VERTICES];

  // finish the last pending compare and hold the parity until the output frees
  assign tail_move = tail_valid && (!res_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_valid <= 1'b0;
    end else if (last_tok.valid) begin
      tail_valid <= 1'b1;
    end else if (tail_move) begin
      tail_valid <= 1'b0;
    end
    if (last_tok.valid) begin
      tail_parity <= last_tok.parity ^ pip_pkg::crosses(last_tok.pend);
    end
  end

  // busy from query acceptance until its parity leaves the tail stage
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (item_acc && items.mode) begin
      busy <= 1'b1;
    end else if (tail_move) begin
      busy <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (tail_move) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
    if (tail_move) begin
      res_parity <= tail_parity;
    end
  end

  assign results.valid      = res_valid;
  assign results.inside_res = res_parity;

  // checks
  `ASSERT_ALWAYS(a_one_query, clk, rst, $onehot0(tok_valid_vec))
  `ASSERT_ALWAYS(a_tok_busy, clk, rst, !(|tok_valid_vec) || busy)
  `ASSERT_ALWAYS(a_tail_free, clk, rst, !(tail_valid && last_tok.valid))
  `ASSERT_NEXT(a_tail_to_res, clk, rst, tail_move, res_valid && !tail_valid && !busy)

endmodule

// ----- hdl/pip_cell.sv -----
// one vertex cell: holds a vertex and tests the edge that starts at it
module pip_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  pip_pkg::load_t   load,
  input  pip_pkg::count_t  n_eff,
  input  pip_pkg::vertex_t v_next,
  input  pip_pkg::vertex_t v_first,
  input  pip_pkg::token_t  tok_in,
  output pip_pkg::vertex_t vertex,
  output pip_pkg::token_t  tok_out
);

  pip_pkg::vertex_t b;
  pip_pkg::coord_t  ax, ay, bx, by, px, py;
  pip_pkg::diff_t   d_py, d_bx, d_px, d_by;
  pip_pkg::prod_t   lhs, rhs;
  logic             active, is_last, skip, dy_pos;
  pip_pkg::token_t  tok_next;

  always_ff @(posedge clk) begin
    if (load.en && (32'(load.index) == IDX)) begin
      vertex <= load.v;
    end
  end

  always_comb begin
    active  = 32'(n_eff) > IDX;
    is_last = 32'(n_eff) == IDX + 1;
    b       = is_last ? v_first : v_next;
    ax      = vertex.x;
    ay      = vertex.y;
    bx      = b.x;
    by      = b.y;
    px      = tok_in.pt.x;
    py      = tok_in.pt.y;
    dy_pos  = $signed(by) > $signed(ay);
    // horizontal edge, or point below min y, or at or above max y
    skip    = (ay == by) ||
              (dy_pos ? ($signed(py) < $signed(ay) || $signed(py) >= $signed(by))
                      : ($signed(py) < $signed(by) || $signed(py) >= $signed(ay)));
    d_py    = pip_pkg::DIFF_W'(py) - pip_pkg::DIFF_W'(ay);
    d_bx    = pip_pkg::DIFF_W'(bx) - pip_pkg::DIFF_W'(ax);
    d_px    = pip_pkg::DIFF_W'(px) - pip_pkg::DIFF_W'(ax);
    d_by    = pip_pkg::DIFF_W'(by) - pip_pkg::DIFF_W'(ay);
    lhs     = d_py * d_bx;
    rhs     = d_px * d_by;

    tok_next             = tok_in;
    tok_next.parity      = tok_in.parity ^ pip_pkg::crosses(tok_in.pend);
    tok_next.pend.take   = tok_in.valid && active && !skip;
    tok_next.pend.dy_pos = dy_pos;
    tok_next.pend.lhs    = lhs;
    tok_next.pend.rhs    = rhs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.pt     <= tok_next.pt;
    tok_out.parity <= tok_next.parity;
    tok_out.pend   <= tok_next.pend;
  end

endmodule
